>>> hw/rtl/pcs_pkg.sv
package pcs_pkg;

  localparam int MAX_CHUNK = 1024;
  // open run length never exceeds MAX_CHUNK
  localparam int LEN_W     = $clog2(MAX_CHUNK + 1);
  localparam int CHUNK_W   = 11;

  localparam int QDEPTH    = 4;
  localparam int QIDX_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_LETTERS  = 4'd1;
  localparam logic [3:0] ST_DIGIT1   = 4'd2;
  localparam logic [3:0] ST_SEP      = 4'd3;
  localparam logic [3:0] ST_APOS     = 4'd4;
  localparam logic [3:0] ST_APOS2    = 4'd5;
  localparam logic [3:0] ST_PUNCT    = 4'd6;
  localparam logic [3:0] ST_PUNCT_NL = 4'd7;
  localparam logic [3:0] ST_WS       = 4'd8;

  typedef struct packed {
    logic [CHUNK_W-1:0] chunk_length;
    logic               cut_short;
    logic               final_chunk;
  } res_t;

  typedef struct packed {
    logic [3:0]       state;
    logic [LEN_W-1:0] len;
    logic [7:0]       h0;
    logic [7:0]       h1;
  } split_state_t;

  // up to two result words produced by one byte
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

>>> hw/rtl/pcs_rules.sv
module pcs_rules
  import pcs_pkg::*;
(
  input  split_state_t cur,
  input  logic [7:0]   text_byte,
  input  logic         end_of_text,
  output split_state_t nxt,
  output push_t        push
);

  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_E     = 8'h65;

  localparam logic [2:0] ACT_START   = 3'd0;
  localparam logic [2:0] ACT_EXTEND  = 3'd1;
  localparam logic [2:0] ACT_FINISH  = 3'd2;
  localparam logic [2:0] ACT_HOLD    = 3'd3;
  localparam logic [2:0] ACT_RESTART = 3'd4;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction

  function automatic logic is_decimal(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_nl(input logic [7:0] b);
    return b == 8'h0d || b == 8'h0a;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SPACE || b == 8'h09 || b == 8'h0b || b == 8'h0c;
  endfunction

  logic [7:0]       lb;
  logic             c_alpha, c_digit, c_nl, c_blank, c_punct;
  logic             h_blank;
  logic [2:0]       act;
  logic [3:0]       ext_st;
  logic [3:0]       start_st;
  logic [LEN_W-1:0] len_inc;
  logic             v1, v2, v3;
  res_t             e1, e2, e3;

  assign c_alpha = is_alpha(text_byte);
  assign c_digit = is_decimal(text_byte);
  assign c_nl    = is_nl(text_byte);
  assign c_blank = is_blank(text_byte);
  assign c_punct = !c_alpha && !c_digit && !c_nl && !c_blank;
  assign lb      = (text_byte >= 8'h41 && text_byte <= 8'h5a) ? text_byte + 8'd32 : text_byte;
  assign h_blank = is_blank(cur.h0);
  assign len_inc = cur.len + LEN_W'(1);

  assign start_st = c_nl              ? ST_IDLE    :
                    c_alpha           ? ST_LETTERS :
                    c_digit           ? ST_DIGIT1  :
                    text_byte == CH_APOS ? ST_APOS : ST_SEP;

  // rule decision for this byte
  always_comb begin
    act    = ACT_RESTART;
    ext_st = ST_IDLE;
    case (cur.state)
      ST_LETTERS: begin
        if (c_alpha) begin
          act = ACT_EXTEND; ext_st = ST_LETTERS;
        end
      end
      ST_DIGIT1: begin
        if (c_digit) act = ACT_FINISH;
      end
      ST_SEP: begin
        if (c_alpha) begin
          act = ACT_EXTEND; ext_st = ST_LETTERS;
        end else if (h_blank) begin
          if (cur.h0 == CH_SPACE && c_punct) begin
            act = ACT_EXTEND; ext_st = ST_PUNCT;
          end else if (c_blank) begin
            act = ACT_EXTEND; ext_st = ST_WS;
          end else if (c_nl) begin
            act = ACT_FINISH;
          end
        end else if (c_punct) begin
          act = ACT_EXTEND; ext_st = ST_PUNCT;
        end else if (c_nl) begin
          act = ACT_EXTEND; ext_st = ST_PUNCT_NL;
        end
      end
      ST_APOS: begin
        if (lb == CH_S || lb == CH_D || lb == CH_M || lb == CH_T) begin
          act = ACT_FINISH;
        end else if (lb == CH_L || lb == CH_V || lb == CH_R) begin
          act = ACT_HOLD;
        end else if (c_alpha) begin
          act = ACT_EXTEND; ext_st = ST_LETTERS;
        end else if (c_punct) begin
          act = ACT_EXTEND; ext_st = ST_PUNCT;
        end else if (c_nl) begin
          act = ACT_EXTEND; ext_st = ST_PUNCT_NL;
        end
      end
      ST_APOS2: begin
        if ((cur.h1 == CH_L && lb == CH_L) || (cur.h1 != CH_L && lb == CH_E)) begin
          act = ACT_FINISH;
        end else if (c_alpha) begin
          act = ACT_EXTEND; ext_st = ST_LETTERS;
        end
      end
      ST_PUNCT: begin
        if (c_punct) begin
          act = ACT_EXTEND; ext_st = ST_PUNCT;
        end else if (c_nl) begin
          act = ACT_EXTEND; ext_st = ST_PUNCT_NL;
        end
      end
      ST_PUNCT_NL: begin
        if (c_nl) begin
          act = ACT_EXTEND; ext_st = ST_PUNCT_NL;
        end
      end
      ST_WS: begin
        if (c_blank) begin
          act = ACT_EXTEND; ext_st = ST_WS;
        end else if (c_nl) begin
          act = ACT_FINISH;
        end
      end
      default: act = ACT_START;
    endcase
  end

  always_comb begin
    nxt = cur;
    v1  = 1'b0;
    v2  = 1'b0;
    e1  = '{chunk_length: CHUNK_W'(len_inc), cut_short: 1'b0, final_chunk: 1'b0};
    e2  = '{chunk_length: CHUNK_W'(1), cut_short: 1'b0, final_chunk: 1'b0};
    case (act)
      ACT_EXTEND: begin
        nxt.state = ext_st;
        if (len_inc >= LEN_W'(MAX_CHUNK)) begin
          v1           = 1'b1;
          e1.cut_short = 1'b1;
          nxt.len      = '0;
        end else begin
          nxt.len = len_inc;
        end
      end
      ACT_FINISH: begin
        v1        = 1'b1;
        nxt.state = ST_IDLE;
        nxt.len   = '0;
      end
      ACT_HOLD: begin
        nxt.h1    = lb;
        nxt.len   = len_inc;
        nxt.state = ST_APOS2;
      end
      ACT_RESTART: begin
        // close the open chunk, then start a new one with this byte
        v1              = cur.len != '0;
        e1.chunk_length = CHUNK_W'(cur.len);
        nxt.state       = start_st;
        nxt.len         = c_nl ? LEN_W'(0) : LEN_W'(1);
        nxt.h0          = text_byte;
        v2              = c_nl;
      end
      default: begin
        nxt.state = start_st;
        nxt.len   = c_nl ? LEN_W'(0) : LEN_W'(1);
        nxt.h0    = text_byte;
        v2        = c_nl;
      end
    endcase

    v3 = end_of_text && nxt.len != '0;
    e3 = '{chunk_length: CHUNK_W'(nxt.len), cut_short: 1'b0, final_chunk: 1'b0};
    if (end_of_text) begin
      nxt.state = ST_IDLE;
      nxt.len   = '0;
    end

    // pack valid results in order
    push.cnt = {1'b0, v1} + {1'b0, v2} + {1'b0, v3};
    push.r0  = v1 ? e1 : (v2 ? e2 : e3);
    push.r1  = (v1 && v2) ? e2 : e3;
    if (end_of_text) begin
      if (push.cnt == 2'd2) push.r1.final_chunk = 1'b1;
      else                  push.r0.final_chunk = 1'b1;
    end
  end

endmodule

>>> hw/rtl/pcs_res_queue.sv
module pcs_res_queue
  import pcs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room2,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  head
);

  res_t              mem [QDEPTH];
  logic [QIDX_W-1:0] rd_r, rd_nxt;
  logic [QIDX_W-1:0] wr_r, wr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;

  assign out_valid = cnt_r != '0;
  assign head      = mem[rd_r];
  assign pop       = out_valid && out_ready;
  assign room2     = cnt_r <= QCNT_W'(QDEPTH - 2);

  assign rd_nxt  = rd_r + QIDX_W'(pop);
  assign wr_nxt  = wr_r + QIDX_W'(push.cnt);
  assign cnt_nxt = cnt_r + QCNT_W'(push.cnt) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wr_r] <= push.r0;
    if (push.cnt == 2'd2) mem[wr_r + QIDX_W'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> cnt_r <= QCNT_W'(QDEPTH - 2))
    else $error("result queue written without room");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue count out of range");

  a_push_width: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd3)
    else $error("more than two results from one byte");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> rd_r == wr_r)
    else $error("empty queue with pointer mismatch");

endmodule

>>> hw/rtl/pretoken_chunk_splitter_unit.sv
// pre-tokenizer chunk splitter
// input channel: one text byte per word (in_text_byte), in_end_of_text
// marks the last byte of a text. result channel: one chunk per word with
// its length, a flag when the chunk was cut at MAX_CHUNK bytes, and a flag
// on the last chunk of the text. a byte may close zero, one or two chunks.
// a chunk closed by a byte reaches out_valid after the byte passes the
// input register and then the result queue write.
// throughput: one byte per cycle while the queue has two free slots; a
// byte that closes two chunks writes two words, which leave in turn
// through the single-word output port, so the rate is set by that port and
// the four-word result queue, which takes a byte only with two free slots.
// receiver stall: results wait in the queue; once it has fewer than two
// free slots the input register holds and in_ready drops.
// reset: rst_n is synchronous active low; the queue is emptied and the
// splitter goes idle with no open chunk. no clearing pass is needed.
module pretoken_chunk_splitter_unit
  import pcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_text_byte,
  input  logic               in_end_of_text,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHUNK_W-1:0] out_chunk_length,
  output logic               out_cut_short,
  output logic               out_final_chunk
);

  logic         in_vld_r;
  logic [7:0]   byte_r;
  logic         eot_r;
  logic         room2;
  logic         step;
  split_state_t st_r, st_nxt;
  push_t        rule_push;
  push_t        push;
  res_t         head;

  assign step     = in_vld_r && room2;
  assign in_ready = !in_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_text_byte;
      eot_r  <= in_end_of_text;
    end
  end

  pcs_rules u_rules (
    .cur         (st_r),
    .text_byte   (byte_r),
    .end_of_text (eot_r),
    .nxt         (st_nxt),
    .push        (rule_push)
  );

  always_comb begin
    push = rule_push;
    if (!step) push.cnt = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{state: ST_IDLE, len: '0, h0: '0, h1: '0};
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

  pcs_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_chunk_length = head.chunk_length;
  assign out_cut_short    = head.cut_short;
  assign out_final_chunk  = head.final_chunk;

  a_len_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.len < LEN_W'(MAX_CHUNK))
    else $error("open chunk reached maximum without a cut");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.state == ST_IDLE |-> st_r.len == '0)
    else $error("idle with an open chunk");

endmodule
